// File: rtl/isim_pkg.sv
// Package for the interval set insert/merge unit.
// Types, codes and widths shared by the interfaces, the compare unit and the top level.
package isim_pkg;

  localparam int VAL_W    = 31;
  localparam int STATUS_W = 3;
  localparam int RCNT_W   = 6;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW       = 3'd0,
    ST_EXT_START = 3'd1,
    ST_EXT_END   = 3'd2,
    ST_MERGED    = 3'd3,
    ST_COVERED   = 3'd4,
    ST_FULL      = 3'd5,
    ST_DUMP      = 3'd6
  } status_t;

  typedef enum logic {
    ACT_ADD  = 1'b0,
    ACT_DUMP = 1'b1
  } action_t;

  typedef struct packed {
    val_t lo;
    val_t hi;
  } ent_t;

  typedef struct packed {
    logic below;
    logic covered;
    logic touch_hi;
    logic touch_lo;
  } cmp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CK,
    S_NEXT_CK,
    S_DN_RD,
    S_DN_WR,
    S_UP_RD,
    S_UP_WR,
    S_DP_RD,
    S_DP_WT,
    S_EMIT
  } state_t;

endpackage

// File: rtl/isim_if.sv
// Valid/ready channel interfaces for the interval set unit.
// Depends on isim_pkg for field types.
interface isim_in_if import isim_pkg::*; ();
  logic valid;
  logic ready;
  logic action;
  val_t value;

  modport source(output valid, action, value, input ready);
  modport sink(input valid, action, value, output ready);
endinterface

interface isim_out_if import isim_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  val_t                range_low;
  val_t                range_high;
  logic                range_valid;
  logic [RCNT_W-1:0]   range_count;
  logic                last;

  modport source(output valid, status, range_low, range_high, range_valid, range_count, last,
                 input ready);
  modport sink(input valid, status, range_low, range_high, range_valid, range_count, last,
               output ready);
endinterface

// File: rtl/isim_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isim_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/isim_cmp.sv
// Shared compare unit: relates one value to one stored interval.
// Depends on isim_pkg. The below and touch compares are one bit wider than the value.
module isim_cmp import isim_pkg::*; (
  input  val_t v,
  input  ent_t e,
  output cmp_t flags
);

  logic [VAL_W:0] v_x;
  logic [VAL_W:0] lo_x;
  logic [VAL_W:0] hi_p1;
  logic [VAL_W:0] v_p1;

  assign v_x   = {1'b0, v};
  assign lo_x  = {1'b0, e.lo};
  assign hi_p1 = {1'b0, e.hi} + {{VAL_W{1'b0}}, 1'b1};
  assign v_p1  = v_x + {{VAL_W{1'b0}}, 1'b1};

  assign flags.below    = hi_p1 < v_x;
  assign flags.covered  = (e.lo <= v) && (v <= e.hi);
  assign flags.touch_hi = hi_p1 == v_x;
  assign flags.touch_lo = lo_x == v_p1;

endmodule

// File: rtl/interval_set_insert_merge_unit.sv
// Top level of the interval set insert/merge unit: sequencer, entry RAM, output register.
// Depends on isim_pkg, isim_if, isim_ram and isim_cmp.
//
// Keeps up to MAX_INTERVALS sorted, disjoint, non-touching closed intervals in one RAM
// of {start, end} pairs, and works on one transaction at a time (in_ch.ready is low while
// busy). An add scans the table from the lowest entry through one RAM read port and one
// shared comparator; a new entry or a merge then moves the entries above the insertion
// point by one place. The result status is loaded into the output register.
// A dump reads the stored intervals from the lowest up and emits one result per interval,
// waiting while the result side stalls.
// No clearing pass follows reset; the unit is ready on the first cycle after reset.
module interval_set_insert_merge_unit import isim_pkg::*; #(
  parameter int MAX_INTERVALS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  isim_in_if.sink           in_ch,
  isim_out_if.source        out_ch
);

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);
  localparam logic [CW-1:0] FULL = CW'(MAX_INTERVALS);

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  val_t            v_r, v_nxt;
  ent_t            cur_r, cur_nxt;
  status_t         st_r, st_nxt;

  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  val_t            out_lo_r, out_lo_nxt;
  val_t            out_hi_r, out_hi_nxt;
  logic            out_rv_r, out_rv_nxt;
  logic [CW-1:0]   out_cnt_r, out_cnt_nxt;
  logic            out_last_r, out_last_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  ent_t            ram_wdata, ram_rdata;
  cmp_t            flags;

  logic            out_free;
  logic [CW-1:0]   idx_p1, idx_p2, k_m1, k_p1;

  assign out_free = !out_valid_r || out_ch.ready;
  assign idx_p1   = idx_r + ONE;
  assign idx_p2   = idx_r + TWO;
  assign k_m1     = k_r - ONE;
  assign k_p1     = k_r + ONE;

  isim_ram #(
    .WIDTH ($bits(ent_t)),
    .DEPTH (MAX_INTERVALS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  isim_cmp u_cmp (
    .v     (v_r),
    .e     (ram_rdata),
    .flags (flags)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    v_nxt          = v_r;
    cur_nxt        = cur_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_lo_nxt     = out_lo_r;
    out_hi_nxt     = out_hi_r;
    out_rv_nxt     = out_rv_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[AW-1:0];
    in_ch.ready    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          v_nxt   = in_ch.value;
          idx_nxt = '0;
          k_nxt   = '0;
          if (action_t'(in_ch.action) == ACT_DUMP) begin
            if (count_r == '0) begin
              st_nxt    = ST_DUMP;
              state_nxt = S_EMIT;
            end else begin
              state_nxt = S_DP_RD;
            end
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: begin
        if (idx_r < count_r) begin
          ram_re    = 1'b1;
          state_nxt = S_SCAN_CK;
        end else if (count_r == FULL) begin
          st_nxt    = ST_FULL;
          state_nxt = S_EMIT;
        end else begin
          k_nxt     = count_r;
          state_nxt = S_UP_RD;
        end
      end

      S_SCAN_CK: begin
        cur_nxt = ram_rdata;
        if (flags.below) begin
          idx_nxt   = idx_p1;
          state_nxt = S_SCAN_RD;
        end else if (flags.covered) begin
          st_nxt    = ST_COVERED;
          state_nxt = S_EMIT;
        end else if (flags.touch_hi) begin
          if (idx_p1 < count_r) begin
            ram_re    = 1'b1;
            ram_raddr = idx_p1[AW-1:0];
            state_nxt = S_NEXT_CK;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = '{lo: ram_rdata.lo, hi: v_r};
            st_nxt    = ST_EXT_END;
            state_nxt = S_EMIT;
          end
        end else if (flags.touch_lo) begin
          ram_we    = 1'b1;
          ram_wdata = '{lo: v_r, hi: ram_rdata.hi};
          st_nxt    = ST_EXT_START;
          state_nxt = S_EMIT;
        end else if (count_r == FULL) begin
          st_nxt    = ST_FULL;
          state_nxt = S_EMIT;
        end else begin
          k_nxt     = count_r;
          state_nxt = S_UP_RD;
        end
      end

      S_NEXT_CK: begin
        ram_we = 1'b1;
        if (flags.touch_lo) begin
          ram_wdata = '{lo: cur_r.lo, hi: ram_rdata.hi};
          k_nxt     = idx_p2;
          state_nxt = S_DN_RD;
        end else begin
          ram_wdata = '{lo: cur_r.lo, hi: v_r};
          st_nxt    = ST_EXT_END;
          state_nxt = S_EMIT;
        end
      end

      S_DN_RD: begin
        if (k_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = k_r[AW-1:0];
          state_nxt = S_DN_WR;
        end else begin
          count_nxt = count_r - ONE;
          st_nxt    = ST_MERGED;
          state_nxt = S_EMIT;
        end
      end

      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_m1[AW-1:0];
        k_nxt     = k_p1;
        state_nxt = S_DN_RD;
      end

      S_UP_RD: begin
        if (k_r > idx_r) begin
          ram_re    = 1'b1;
          ram_raddr = k_m1[AW-1:0];
          state_nxt = S_UP_WR;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = '{lo: v_r, hi: v_r};
          count_nxt = count_r + ONE;
          st_nxt    = ST_NEW;
          state_nxt = S_EMIT;
        end
      end

      S_UP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r[AW-1:0];
        k_nxt     = k_m1;
        state_nxt = S_UP_RD;
      end

      S_DP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_r[AW-1:0];
        state_nxt = S_DP_WT;
      end

      S_DP_WT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_DUMP;
          out_lo_nxt     = ram_rdata.lo;
          out_hi_nxt     = ram_rdata.hi;
          out_rv_nxt     = 1'b1;
          out_cnt_nxt    = count_r;
          out_last_nxt   = k_p1 == count_r;
          k_nxt          = k_p1;
          state_nxt      = (k_p1 == count_r) ? S_IDLE : S_DP_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_lo_nxt     = '0;
          out_hi_nxt     = '0;
          out_rv_nxt     = 1'b0;
          out_cnt_nxt    = count_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    v_r          <= v_nxt;
    cur_r        <= cur_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_lo_r     <= out_lo_nxt;
    out_hi_r     <= out_hi_nxt;
    out_rv_r     <= out_rv_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.range_low   = out_lo_r;
  assign out_ch.range_high  = out_hi_r;
  assign out_ch.range_valid = out_rv_r;
  assign out_ch.range_count = RCNT_W'(out_cnt_r);
  assign out_ch.last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("entry count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> state_r != S_IDLE)
    else $error("sequencer idle right after a transaction was taken");

  a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (CW'(ram_waddr) <= count_r))
    else $error("entry write beyond the filled part of the table");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_UP_RD && state_r != S_DN_RD |=> count_r == $past(count_r))
    else $error("entry count changed outside an insert or merge");

endmodule

// File: bench/interval_set_checker.sv
// Scoreboard for the interval set insert/merge unit: watches both channels, predicts
// the result transactions of every accepted input and compares them field by field.
// Depends on isim_pkg and the channel interfaces in isim_if.
`timescale 1ns / 1ps

module interval_set_checker import isim_pkg::*; #(
  parameter int MAX_INTERVALS = 32
) (
  input  logic clk,
  input  logic rst_n,
  isim_in_if   in_ch,
  isim_out_if  out_ch,
  output int   fails,
  output int   pending
);

  typedef struct packed {
    status_t           status;
    val_t              lo;
    val_t              hi;
    logic              rv;
    logic [RCNT_W-1:0] cnt;
    logic              last;
  } range_rec_t;

  val_t       starts_q [MAX_INTERVALS];
  val_t       ends_q   [MAX_INTERVALS];
  int         n_ent;
  range_rec_t expected_ranges [$];

  function automatic range_rec_t make_rec(status_t st, val_t lo, val_t hi, logic rv,
                                          logic last);
    range_rec_t r;
    r.status = st;
    r.lo     = lo;
    r.hi     = hi;
    r.rv     = rv;
    r.cnt    = RCNT_W'(n_ent);
    r.last   = last;
    return r;
  endfunction

  function automatic void queue_rec(range_rec_t r);
    expected_ranges.insert(expected_ranges.size(), r);
  endfunction

  function automatic status_t apply_add(val_t v);
    logic [VAL_W:0] w;
    int i;
    int k;
    w = {1'b0, v};
    i = 0;
    while (i < n_ent && {1'b0, ends_q[i]} + 1'b1 < w) i++;
    if (i < n_ent && starts_q[i] <= v && v <= ends_q[i]) return ST_COVERED;
    if (i < n_ent && {1'b0, ends_q[i]} + 1'b1 == w) begin
      if (i + 1 < n_ent && {1'b0, starts_q[i+1]} == w + 1'b1) begin
        ends_q[i] = ends_q[i+1];
        for (k = i + 1; k < n_ent - 1; k++) begin
          starts_q[k] = starts_q[k+1];
          ends_q[k]   = ends_q[k+1];
        end
        n_ent--;
        return ST_MERGED;
      end
      ends_q[i] = v;
      return ST_EXT_END;
    end
    if (i < n_ent && {1'b0, starts_q[i]} == w + 1'b1) begin
      starts_q[i] = v;
      return ST_EXT_START;
    end
    if (n_ent >= MAX_INTERVALS) return ST_FULL;
    for (k = n_ent; k > i; k--) begin
      starts_q[k] = starts_q[k-1];
      ends_q[k]   = ends_q[k-1];
    end
    starts_q[i] = v;
    ends_q[i]   = v;
    n_ent++;
    return ST_NEW;
  endfunction

  task automatic predict_item(action_t act, val_t v);
    status_t st;
    int k;
    if (act == ACT_ADD) begin
      st = apply_add(v);
      queue_rec(make_rec(st, '0, '0, 1'b0, 1'b1));
    end else if (n_ent == 0) begin
      queue_rec(make_rec(ST_DUMP, '0, '0, 1'b0, 1'b1));
    end else begin
      for (k = 0; k < n_ent; k++)
        queue_rec(make_rec(ST_DUMP, starts_q[k], ends_q[k], 1'b1, k == n_ent - 1));
    end
  endtask

  task automatic log_fault(string what, range_rec_t got, range_rec_t want);
    fails++;
    if (fails <= 10) begin
      $write("%0t %s: got st=%0d lo=%0d hi=%0d v=%0b n=%0d last=%0b | ",
             $realtime, what, got.status, got.lo, got.hi, got.rv, got.cnt, got.last);
      $display("exp st=%0d lo=%0d hi=%0d v=%0b n=%0d last=%0b",
               want.status, want.lo, want.hi, want.rv, want.cnt, want.last);
    end
  endtask

  task automatic check_result();
    range_rec_t got;
    range_rec_t want;
    got.status = status_t'(out_ch.status);
    got.lo     = out_ch.range_low;
    got.hi     = out_ch.range_high;
    got.rv     = out_ch.range_valid;
    got.cnt    = out_ch.range_count;
    got.last   = out_ch.last;
    if (expected_ranges.size() == 0) begin
      log_fault("unexpected transaction", got, '0);
    end else begin
      want = expected_ranges.pop_front();
      if (got !== want) log_fault("mismatch", got, want);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_ent = 0;
      fails = 0;
      expected_ranges.delete();
      pending = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (in_ch.valid && in_ch.ready) predict_item(action_t'(in_ch.action), in_ch.value);
      pending = expected_ranges.size();
    end
  end

endmodule

// File: bench/tb_interval_set_insert_merge_unit.sv
// Testbench top for the interval set insert/merge unit: clock, reset, stimulus with
// bursty sender and stalling receiver, watchdog and verdict.
// Depends on isim_pkg, isim_if, the unit itself and interval_set_checker.
`timescale 1ns / 1ps

module tb_interval_set_insert_merge_unit import isim_pkg::*; ();

  localparam int   MAX_INTERVALS  = 32;
  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   LONG_HOLD      = 400;
  localparam int   TAIL_CYCLES    = 150;
  localparam val_t V_TOP          = '1;

  logic clk = 1'b0;
  logic rst_n;
  int   fails;
  int   pending;
  int   stall_cycles;
  int   burst_left;
  bit   hold_off_req;

  isim_in_if  in_ch();
  isim_out_if out_ch();

  interval_set_insert_merge_unit #(.MAX_INTERVALS(MAX_INTERVALS)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  interval_set_checker #(.MAX_INTERVALS(MAX_INTERVALS)) chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .fails  (fails),
    .pending(pending)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : receiver
    int mode;
    int span;
    int j;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(8, 60);
        for (j = 0; j < span && !hold_off_req; j++) begin
          case (mode)
            0: begin
              out_ch.ready = 1'b1;
            end
            1: begin
              out_ch.ready = 1'($urandom_range(0, 1));
            end
            default: begin
              out_ch.ready = ($urandom_range(0, 5) == 0);
            end
          endcase
          @(negedge clk);
        end
      end
    end
  end

  task automatic offer(input action_t act, input val_t v);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid  = 1'b1;
    in_ch.action = act;
    in_ch.value  = v;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic random_round(input int items, input int base, input int span);
    int j;
    int pick;
    for (j = 0; j < items; j++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        offer(ACT_DUMP, val_t'($urandom));
      else if (pick <= 2)
        offer(ACT_ADD, val_t'($urandom));
      else if (pick == 3)
        offer(ACT_ADD, V_TOP - val_t'($urandom_range(0, 8)));
      else
        offer(ACT_ADD, val_t'(base + $urandom_range(0, span)));
    end
  endtask

  initial begin : stimulus
    int k;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_ADD;
    in_ch.value  = '0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    offer(ACT_DUMP, '0);
    offer(ACT_ADD, V_TOP);
    offer(ACT_ADD, '0);
    offer(ACT_ADD, 31'd10);
    offer(ACT_ADD, 31'd10);
    offer(ACT_ADD, 31'd11);
    offer(ACT_ADD, 31'd9);
    offer(ACT_ADD, 31'd13);
    offer(ACT_ADD, 31'd12);
    offer(ACT_ADD, 31'd1);
    offer(ACT_ADD, V_TOP - 31'd1);
    offer(ACT_ADD, V_TOP - 31'd3);
    offer(ACT_ADD, V_TOP - 31'd2);
    offer(ACT_ADD, 31'd2);
    offer(ACT_ADD, V_TOP);
    offer(ACT_ADD, 31'd7);
    offer(ACT_ADD, 31'd15);
    offer(ACT_ADD, 31'd14);
    offer(ACT_DUMP, V_TOP);

    random_round(90, 100, 60);

    hold_off_req = 1'b1;
    burst_left   = 40;
    random_round(12, 100, 60);
    drain();

    for (k = 0; k < 40; k++) offer(ACT_ADD, val_t'(5000 + 4 * k));
    offer(ACT_DUMP, '0);

    random_round(130, 5000, 170);
    drain();
    random_round(50, 2147483000, 600);
    offer(ACT_DUMP, '0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
